/* rtl/sul_pkg.sv */
// ----------------------------------------------------------------------------
// sul_pkg
// Shared types, codes and constants for the sorted unique list core.
// ----------------------------------------------------------------------------
package sul_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int KEY_W            = 32;
    localparam int CFG_W            = 6;
    localparam int TOTAL_W          = 6;
    localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SHOW   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_ENTRY     = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    // per-cell operation broadcast along the row
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] key_value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [KEY_W-1:0] out_value;
        logic                    last;
        logic [TOTAL_W-1:0]      entry_total;
    } result_t;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] head;
    } cell_ctrl_t;

endpackage

/* rtl/sul_cell.sv */
// ----------------------------------------------------------------------------
// sul_cell
// One slot of the sorted row: compares against the broadcast key and takes
// the key or a neighbor's value on insert, remove and rotate.
// ----------------------------------------------------------------------------
module sul_cell
    import sul_pkg::*;
#(
    parameter int CNT_W = 6,
    parameter int IDX   = 0
)
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [KEY_W-1:0] left_val,
    input  logic                    left_lt,
    input  logic signed [KEY_W-1:0] right_val,
    output logic signed [KEY_W-1:0] val,
    output logic                    lt,
    output logic                    eq
);

    logic signed [KEY_W-1:0] val_reg;
    logic signed [KEY_W-1:0] val_next;
    logic                    occupied;
    logic                    tail;

    assign occupied = count > CNT_W'(IDX);
    assign tail     = count == CNT_W'(IDX + 1);
    assign lt       = occupied && (val_reg < ctrl.key);
    assign eq       = occupied && (val_reg == ctrl.key);
    assign val      = val_reg;

    // entries form a sorted prefix, so "not less" marks the insert/remove point onward
    always_comb
    begin
        val_next = val_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (!lt)
                begin
                    val_next = left_lt ? ctrl.key : left_val;
                end
            end
            OP_REMOVE:
            begin
                if (!lt)
                begin
                    val_next = right_val;
                end
            end
            OP_ROTATE:
            begin
                val_next = tail ? ctrl.head : right_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* rtl/sorted_unique_list_core.sv */
// ----------------------------------------------------------------------------
// sorted_unique_list_core
// Sorted set of distinct signed 32-bit keys held in a row of compare cells.
// ----------------------------------------------------------------------------
// For insert and remove the key is broadcast to every cell, the row shifts
// in place, and the single result appears on result_valid the cycle after
// start is taken, with busy staying low so a new command may follow at
// once. Show rotates the row toward cell 0 once per cycle and streams one
// entry per cycle, so it holds busy until its last entry and returns the row
// to its original order; on an empty list it returns one empty status.
// Results cannot be stalled. The capacity register may be written through
// the cfg channel, which is always ready, while no command is in flight.
module sorted_unique_list_core
    import sul_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             show_reg, show_next;
    logic             valid_reg, valid_next;
    logic [CFG_W-1:0] cap_reg;
    result_t          result_reg, result_next;

    cell_ctrl_t              ctrl;
    logic [1:0]              cell_op;
    logic signed [KEY_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_eq;

    logic accept;
    logic hit;
    logic full;
    logic show_last;

    assign cfg_ready    = 1'b1;
    assign busy         = show_reg;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    assign accept    = start && !busy;
    assign hit       = |cell_eq;
    assign full      = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                    || (CMP_W'(count_reg) >= CMP_W'(CAPACITY));
    assign show_last = idx_reg == (count_reg - 1'b1);

    assign ctrl = '{op: cell_op, key: cmd.key_value, head: cell_val[0]};

    always_comb
    begin
        cell_op = OP_HOLD;
        if (show_reg)
        begin
            cell_op = OP_ROTATE;
        end
        else if (accept)
        begin
            if (cmd.req_type == REQ_INSERT && !hit && !full)
            begin
                cell_op = OP_INSERT;
            end
            else if (cmd.req_type == REQ_REMOVE && hit)
            begin
                cell_op = OP_REMOVE;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [KEY_W-1:0] left_val;
            logic                    left_lt;
            logic signed [KEY_W-1:0] right_val;

            if (gi == 0)
            begin : g_first
                assign left_val = cmd.key_value;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_mid
                assign left_val = cell_val[gi-1];
                assign left_lt  = cell_lt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_val = cell_val[0];
            end
            else
            begin : g_inner
                assign right_val = cell_val[gi+1];
            end

            sul_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .left_val  (left_val),
                .left_lt   (left_lt),
                .right_val (right_val),
                .val       (cell_val[gi]),
                .lt        (cell_lt[gi]),
                .eq        (cell_eq[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        show_next   = show_reg;
        valid_next  = 1'b0;
        result_next = result_reg;

        if (show_reg)
        begin
            valid_next            = 1'b1;
            result_next.status    = ST_ENTRY;
            result_next.out_value = cell_val[0];
            result_next.last      = show_last;
            idx_next              = idx_reg + 1'b1;
            if (show_last)
            begin
                show_next = 1'b0;
            end
        end
        else if (accept)
        begin
            result_next.out_value = '0;
            result_next.last      = 1'b1;
            unique case (cmd.req_type)
                REQ_INSERT:
                begin
                    valid_next = 1'b1;
                    if (hit)
                    begin
                        result_next.status = ST_DUPLICATE;
                    end
                    else if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        result_next.status = ST_INSERTED;
                        count_next         = count_reg + 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    valid_next = 1'b1;
                    if (hit)
                    begin
                        result_next.status    = ST_REMOVED;
                        result_next.out_value = cmd.key_value;
                        count_next            = count_reg - 1'b1;
                    end
                    else
                    begin
                        result_next.status = ST_NOTFOUND;
                    end
                end
                REQ_SHOW:
                begin
                    if (count_reg == '0)
                    begin
                        valid_next         = 1'b1;
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        show_next = 1'b1;
                        idx_next  = '0;
                    end
                end
                default:
                begin
                    valid_next = 1'b0;
                end
            endcase
        end
        result_next.entry_total = TOTAL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            show_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            show_reg  <= show_next;
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

/* rtl/sul_checker.sv */
// ----------------------------------------------------------------------------
// sul_checker
// Port-level checks on command, busy and result timing of the list core.
// ----------------------------------------------------------------------------
module sul_checker
    import sul_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input cmd_t    cmd,
    input logic    result_valid,
    input result_t result
);

    // insert and remove always answer on the next cycle
    a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.req_type == REQ_INSERT || cmd.req_type == REQ_REMOVE))
        |=> result_valid)
        else $error("insert/remove transaction got no result");

    // a show stream has no gaps and keeps the core busy until its last entry
    a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> result_valid)
        else $error("gap in show stream");

    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("core not busy during show stream");

    a_stream_total: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> (result.entry_total == $past(result.entry_total)))
        else $error("entry total changed during show stream");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_ENTRY) |-> result.last)
        else $error("non-entry result without last");

endmodule

bind sorted_unique_list_core sul_checker u_sul_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sorted_unique_list_core. Directed insert, remove and show
// commands first, then capacity corner cases, then random traffic with
// sender gaps and several capacity settings. A local model of the sorted set
// predicts every result, and a checker compares the results in order.
// ----------------------------------------------------------------------------
module tb_top;
    import sul_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             result_valid;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    // model of the list and its limit register
    logic signed [KEY_W-1:0] held_keys[$];
    logic [CFG_W-1:0]        capacity_reg = CAP_RESET;
    result_t                 expected_results[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int cmds_taken    = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int peak_entries  = 0;
    int full_reports  = 0;

    sorted_unique_list_core #(.CAPACITY(LIST_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // set model
    // ------------------------------------------------------------------
    function automatic void predict_list_results(cmd_t c);
        int      lim;
        int      pos;
        int      hit;
        result_t r;
        lim = (int'(capacity_reg) < LIST_DEPTH) ? int'(capacity_reg) : LIST_DEPTH;
        hit = -1;
        for (int i = 0; i < held_keys.size(); i++)
        begin
            if (hit < 0 && held_keys[i] == c.key_value)
                hit = i;
        end
        r = '0;
        r.last = 1'b1;
        case (c.req_type)
            REQ_INSERT:
            begin
                // duplicate wins over full
                if (hit >= 0)
                    r.status = ST_DUPLICATE;
                else if (held_keys.size() >= lim)
                    r.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held_keys.size() && held_keys[pos] < c.key_value)
                        pos++;
                    held_keys.insert(pos, c.key_value);
                    r.status = ST_INSERTED;
                end
                if (r.status == ST_FULL)
                    full_reports++;
                r.entry_total = TOTAL_W'(held_keys.size());
                expected_results.push_back(r);
            end
            REQ_REMOVE:
            begin
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    held_keys.delete(hit);
                    r.status    = ST_REMOVED;
                    r.out_value = c.key_value;
                end
                r.entry_total = TOTAL_W'(held_keys.size());
                expected_results.push_back(r);
            end
            REQ_SHOW:
            begin
                r.entry_total = TOTAL_W'(held_keys.size());
                if (held_keys.size() == 0)
                begin
                    r.status = ST_EMPTY;
                    expected_results.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < held_keys.size(); i++)
                    begin
                        r.status    = ST_ENTRY;
                        r.out_value = held_keys[i];
                        r.last      = (i == held_keys.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: ; // unused code: no result, no state change
        endcase
        if (held_keys.size() > peak_entries)
            peak_entries = held_keys.size();
    endfunction

    function automatic void report_mismatch(string what, result_t exp_r, result_t act_r);
        error_count++;
        if (error_count <= 10)
            $display({"[%0t] %s: expected st=%0d val=%0d last=%0b total=%0d,",
                      " got st=%0d val=%0d last=%0b total=%0d"},
                     $time, what, exp_r.status, exp_r.out_value, exp_r.last, exp_r.entry_total,
                     act_r.status, act_r.out_value, act_r.last, act_r.entry_total);
    endfunction

    // result check, then model update for transactions taken at this edge
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (result_valid)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing pending", '0, result);
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result !== exp_r)
                        report_mismatch("result mismatch", exp_r, result);
                end
            end
            if (start && !busy)
            begin
                cmds_taken++;
                predict_list_results(cmd);
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                capacity_reg = cfg_data;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d results still pending", expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // start stays high on return so back-to-back commands need no gap
    task automatic send_cmd(input logic [1:0] req, input logic signed [KEY_W-1:0] key);
        cmd_t c;
        c.req_type  = req;
        c.key_value = key;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // register write only with nothing in flight
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        // let the model log the last transaction before checking what is pending
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            4, 5:    return KEY_W'(int'($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_basic_ops();
        send_cmd(REQ_SHOW, '0);
        send_cmd(REQ_REMOVE, 32'sd5);
        send_cmd(REQ_INSERT, 32'h7fff_ffff);
        send_cmd(REQ_INSERT, 32'h8000_0000);
        send_cmd(REQ_INSERT, '0);
        send_cmd(REQ_INSERT, '1);
        send_cmd(REQ_INSERT, '0);
        send_cmd(REQ_SHOW, 32'h5a5a_a5a5);
        send_cmd(REQ_REMOVE, 32'sd12345);
        send_cmd(REQ_REMOVE, 32'h8000_0000);
        send_cmd(REQ_UNUSED, 32'h7fff_ffff);
        send_cmd(REQ_REMOVE, 32'h7fff_ffff);
        send_cmd(REQ_SHOW, '0);
    endtask

    // list holds {-1, 0} on entry
    task automatic test_capacity_limits();
        write_capacity('0);
        send_cmd(REQ_INSERT, 32'sd7);
        send_cmd(REQ_INSERT, '0);
        write_capacity(6'd1);
        send_cmd(REQ_INSERT, 32'sd9);
        send_cmd(REQ_REMOVE, '1);
        send_cmd(REQ_INSERT, 32'sd9);
        send_cmd(REQ_REMOVE, '0);
        send_cmd(REQ_INSERT, 32'sd9);
        send_cmd(REQ_INSERT, 32'sd10);
        write_capacity('1);
        send_cmd(REQ_INSERT, 32'sd10);
        send_cmd(REQ_SHOW, '0);
    endtask

    task automatic run_random(input int n, input int idle_pct, input int ins_pct,
                              input int rem_pct);
        int                      done;
        int                      r;
        logic signed [KEY_W-1:0] key;
        done = 0;
        while (done < n)
        begin
            r   = $urandom_range(0, 99);
            key = pick_key();
            if (r < ins_pct)
            begin
                // reinsert a held key now and then to hit duplicates
                if (held_keys.size() > 0 && $urandom_range(0, 4) == 0)
                    key = held_keys[$urandom_range(0, held_keys.size() - 1)];
                send_cmd(REQ_INSERT, key);
                done++;
            end
            else if (r < ins_pct + rem_pct)
            begin
                if (held_keys.size() > 0 && $urandom_range(0, 3) != 0)
                    key = held_keys[$urandom_range(0, held_keys.size() - 1)];
                send_cmd(REQ_REMOVE, key);
                done++;
            end
            else if (r < 97)
            begin
                send_cmd(REQ_SHOW, key);
                done++;
            end
            else
                send_cmd(REQ_UNUSED, key);
            // each cycle idles with the given odds
            while ($urandom_range(0, 99) < idle_pct)
                idle_sender(1);
        end
    endtask

    task automatic test_random_fill();
        write_capacity(6'd32);
        run_random(100, 0, 70, 15);
    endtask

    task automatic test_random_churn();
        write_capacity(6'd63);
        run_random(80, 66, 45, 40);
    endtask

    // limit drops below the current count
    task automatic test_lowered_capacity();
        write_capacity(6'd3);
        run_random(80, 20, 40, 45);
    endtask

    task automatic test_single_slot();
        write_capacity(6'd1);
        run_random(50, 0, 50, 35);
    endtask

    task automatic test_mixed_idle();
        write_capacity(6'd32);
        run_random(40, 20, 50, 35);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_capacity_limits();
        test_random_fill();
        test_random_churn();
        test_lowered_capacity();
        test_single_slot();
        test_mixed_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d commands, %0d results checked, %0d capacity writes, %0d full reports",
                 cmds_taken, results_seen, cfg_writes, full_reports);
        $display("largest list held: %0d entries, mismatches: %0d", peak_entries, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sorted_unique_list_core.f */
rtl/sul_pkg.sv
rtl/sul_cell.sv
rtl/sorted_unique_list_core.sv
rtl/sul_checker.sv
tb/sv/tb_top.sv
